FILE: rtl/astarp_pkg.sv
// Shared constants, types and helpers for the radius-graph A* path core.
// No dependencies; imported by astarp_dist, the top level and the testbench.
package astarp_pkg;

    localparam int MAX_NODES  = 64;
    localparam int COORD_BITS = 24;
    localparam int IDX_W      = $clog2(MAX_NODES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int D2_W       = 2 * COORD_BITS + 2;
    localparam int ROOT_W     = D2_W / 2;
    localparam int COST_W     = 32;
    localparam int STAMP_W    = 16;
    localparam int RADIUS_W   = 25;
    localparam int COORD3_W   = 3 * COORD_BITS;
    localparam int S_DATA_W   = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = ((IDX_W + 3 * COORD_BITS + 7) / 8) * 8;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FIND  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_PATH  = 2'd0;
    localparam logic [1:0] ST_NOPATH = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [COST_W-1:0]  g;
        logic [COST_W-1:0]  h;
        logic [IDX_W-1:0]   came;
        logic [STAMP_W-1:0] stamp;
    } node_rec_t;

    localparam int NODE_REC_W = $bits(node_rec_t);

    typedef struct packed {
        logic start;
        logic root_en;
    } dist_req_t;

    function automatic logic [COORD_BITS-1:0] abs_diff(coord_t a, coord_t b);
        logic signed [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        if (d[COORD_BITS]) begin
            d = -d;
        end
        return d[COORD_BITS-1:0];
    endfunction

endpackage

FILE: rtl/astarp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module astarp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/astarp_dist.sv
// Distance unit: squared 3D distance on one shared multiplier, then an optional
// bit-pair integer square root, one step per cycle. Depends on astarp_pkg.
module astarp_dist (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  astarp_pkg::dist_req_t    req,
    input  astarp_pkg::coord_t       a_x,
    input  astarp_pkg::coord_t       a_y,
    input  astarp_pkg::coord_t       a_z,
    input  astarp_pkg::coord_t       b_x,
    input  astarp_pkg::coord_t       b_y,
    input  astarp_pkg::coord_t       b_z,
    output logic                     done,
    output logic [astarp_pkg::D2_W-1:0]   d2,
    output logic [astarp_pkg::ROOT_W-1:0] root
);
    import astarp_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_SQRT = 2'd2;
    localparam int CW = $clog2(ROOT_W + 1);

    logic [1:0]              ph_reg;
    logic [CW-1:0]           cnt_reg;
    logic [COORD_BITS-1:0]   dx_reg, dy_reg, dz_reg, mop;
    logic [2*COORD_BITS-1:0] prod_reg;
    logic [D2_W-1:0]         acc_reg, rem_reg, res_reg, bit_reg, sum;
    logic [D2_W:0]           trial;
    logic                    root_en_reg, done_reg;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    mop = dx_reg;
            2'd1:    mop = dy_reg;
            default: mop = dz_reg;
        endcase
        sum   = acc_reg + D2_W'(prod_reg);
        trial = {1'b0, res_reg} + {1'b0, bit_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (ph_reg)
                PH_IDLE: begin
                    if (req.start) begin
                        dx_reg      <= abs_diff(a_x, b_x);
                        dy_reg      <= abs_diff(a_y, b_y);
                        dz_reg      <= abs_diff(a_z, b_z);
                        prod_reg    <= '0;
                        acc_reg     <= '0;
                        cnt_reg     <= '0;
                        root_en_reg <= req.root_en;
                        ph_reg      <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    acc_reg <= sum;
                    if (cnt_reg != CW'(3)) begin
                        prod_reg <= mop * mop;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end else if (root_en_reg) begin
                        rem_reg <= sum;
                        res_reg <= '0;
                        bit_reg <= D2_W'(1) << (D2_W - 2);
                        cnt_reg <= '0;
                        ph_reg  <= PH_SQRT;
                    end else begin
                        done_reg <= 1'b1;
                        ph_reg   <= PH_IDLE;
                    end
                end
                PH_SQRT: begin
                    if ({1'b0, rem_reg} >= trial) begin
                        rem_reg <= rem_reg - trial[D2_W-1:0];
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(ROOT_W - 1)) begin
                        done_reg <= 1'b1;
                        ph_reg   <= PH_IDLE;
                    end
                end
                default: ph_reg <= PH_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign d2   = acc_reg;
    assign root = res_reg[ROOT_W-1:0];
endmodule

FILE: rtl/astar_radius_graph_path_core.sv
// Top level of the radius-graph A* path core: sequencer, output register and
// the coordinate, search-state and path-stack RAMs. Depends on astarp_pkg,
// astarp_ram and astarp_dist.
//
// The core stores up to 64 points (Q16.8 x/y/z) and answers path requests.
// A load or clear request is applied on acceptance; a full table answers a
// load with status 3. A find-path request snaps start and goal to the nearest
// stored points (one scan of the table for each), then runs A* where two
// points are linked when their distance, floor(sqrt) in 1/256 units, is at
// most connection_radius. Each expansion scans the open set (one RAM read per
// stored point) and then every other point through the shared distance unit
// (25-step square root), and through it again for the heuristic when the
// candidate's cost improves. A query on N points therefore takes roughly N
// expansions, each dominated by the square-root unit. The path comes out
// start to goal, one result per node with tlast on the goal, or as a single
// status result. A finished result waits in the output register while the
// core goes back to taking requests. connection_radius is written through
// cfg_wen/cfg_wdata while idle: a rule for the user, not enforced by the core.
module astar_radius_graph_path_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [astarp_pkg::RADIUS_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pos_x, pos_y, pos_z, end_x, end_y, end_z
    input  logic [astarp_pkg::S_DATA_W-1:0] s_tdata,
    // operation
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // node_index, out_x, out_y, out_z, zero fill
    output logic [astarp_pkg::M_DATA_W-1:0] m_tdata,
    // status
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import astarp_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_NR_RD  = 5'd1;
    localparam logic [4:0] S_NR_GO  = 5'd2;
    localparam logic [4:0] S_NR_WT  = 5'd3;
    localparam logic [4:0] S_INIT_E = 5'd4;
    localparam logic [4:0] S_INIT_S = 5'd5;
    localparam logic [4:0] S_INIT_H = 5'd6;
    localparam logic [4:0] S_INIT_W = 5'd7;
    localparam logic [4:0] S_SEL    = 5'd8;
    localparam logic [4:0] S_EX_C   = 5'd9;
    localparam logic [4:0] S_EX_RD  = 5'd10;
    localparam logic [4:0] S_EX_GO  = 5'd11;
    localparam logic [4:0] S_EX_WT  = 5'd12;
    localparam logic [4:0] S_EX_G   = 5'd13;
    localparam logic [4:0] S_EX_HW  = 5'd14;
    localparam logic [4:0] S_PW     = 5'd15;
    localparam logic [4:0] S_PW_WT  = 5'd16;
    localparam logic [4:0] S_EM_RD  = 5'd17;
    localparam logic [4:0] S_EM_P   = 5'd18;
    localparam logic [4:0] S_EM_O   = 5'd19;
    localparam logic [4:0] S_STAT   = 5'd20;

    // ---------------- registers ----------------
    logic [4:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [RADIUS_W-1:0] radius_reg;
    coord_t              qx_reg, qy_reg, qz_reg, qx_next, qy_next, qz_next;
    coord_t              gx_reg, gy_reg, gz_reg, gx_next, gy_next, gz_next;
    coord_t              enx_reg, eny_reg, enz_reg, enx_next, eny_next, enz_next;
    coord_t              cx_reg, cy_reg, cz_reg, cx_next, cy_next, cz_next;
    logic                phase_reg, phase_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [D2_W-1:0]     bd_reg, bd_next;
    logic [IDX_W-1:0]    bi_reg, bi_next;
    logic [IDX_W-1:0]    s_reg, s_next, e_reg, e_next;
    logic [MAX_NODES-1:0] open_reg, open_next, gval_reg, gval_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    logic                found_reg, found_next;
    logic [COST_W:0]     bf_reg, bf_next;
    logic [STAMP_W-1:0]  bs_reg, bs_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [COST_W-1:0]   bg_reg, bg_next;
    logic                rdp_reg, rdp_next;
    logic [IDX_W-1:0]    idxd_reg, idxd_next;
    logic [COST_W-1:0]   t_reg, t_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic [IDX_W-1:0]    walk_reg, walk_next;
    logic [1:0]          stat_reg, stat_next;
    logic                ov_reg, ov_next, olast_reg, olast_next;
    logic [1:0]          ost_reg, ost_next;
    logic [IDX_W-1:0]    oidx_reg, oidx_next;
    coord_t              ox_reg, oy_reg, oz_reg, ox_next, oy_next, oz_next;

    // ---------------- RAM ports ----------------
    logic                  cr_we, cr_re, sr_we, sr_re, pr_we, pr_re;
    logic [IDX_W-1:0]      cr_waddr, cr_raddr, sr_waddr, sr_raddr, pr_waddr, pr_raddr;
    logic [COORD3_W-1:0]   cr_wdata, cr_rdata;
    logic [NODE_REC_W-1:0] sr_wdata_v, sr_rdata_v;
    node_rec_t             sr_wdata, sr_rdata;
    logic [IDX_W-1:0]      pr_wdata, pr_rdata;
    coord_t                rx, ry, rz;

    // ---------------- distance unit ----------------
    dist_req_t            dreq;
    coord_t               dax, day, daz;
    logic                 ddone;
    logic [D2_W-1:0]      dd2;
    logic [ROOT_W-1:0]    droot;

    // ---------------- misc comb ----------------
    logic                 s_acc, out_free;
    logic [IDX_W-1:0]     jj;
    logic [COST_W:0]      f_val, t_sum;
    logic [COST_W-1:0]    g_n;

    assign rx = cr_rdata[COORD_BITS-1:0];
    assign ry = cr_rdata[2*COORD_BITS-1:COORD_BITS];
    assign rz = cr_rdata[3*COORD_BITS-1:2*COORD_BITS];
    assign sr_rdata   = node_rec_t'(sr_rdata_v);
    assign sr_wdata_v = NODE_REC_W'(sr_wdata);

    astarp_ram #(.WIDTH(COORD3_W), .DEPTH(MAX_NODES)) u_coord_ram (
        .aclk(aclk), .we(cr_we), .waddr(cr_waddr), .wdata(cr_wdata),
        .re(cr_re), .raddr(cr_raddr), .rdata(cr_rdata)
    );

    astarp_ram #(.WIDTH(NODE_REC_W), .DEPTH(MAX_NODES)) u_state_ram (
        .aclk(aclk), .we(sr_we), .waddr(sr_waddr), .wdata(sr_wdata_v),
        .re(sr_re), .raddr(sr_raddr), .rdata(sr_rdata_v)
    );

    astarp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_path_ram (
        .aclk(aclk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
        .re(pr_re), .raddr(pr_raddr), .rdata(pr_rdata)
    );

    astarp_dist u_dist (
        .aclk(aclk), .aresetn(aresetn), .req(dreq),
        .a_x(dax), .a_y(day), .a_z(daz),
        .b_x(rx), .b_y(ry), .b_z(rz),
        .done(ddone), .d2(dd2), .root(droot)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !ov_reg || m_tready;
    assign jj       = j_reg[IDX_W-1:0];

    // Distance operand A: query point while snapping, current node while
    // scanning neighbors, goal node otherwise. Operand B is the coordinate RAM.
    always_comb begin
        case (state_reg)
            S_NR_RD, S_NR_GO, S_NR_WT: begin
                dax = qx_reg; day = qy_reg; daz = qz_reg;
            end
            S_EX_GO: begin
                dax = cx_reg; day = cy_reg; daz = cz_reg;
            end
            default: begin
                dax = enx_reg; day = eny_reg; daz = enz_reg;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;  count_next = count_reg;
        qx_next = qx_reg; qy_next = qy_reg; qz_next = qz_reg;
        gx_next = gx_reg; gy_next = gy_reg; gz_next = gz_reg;
        enx_next = enx_reg; eny_next = eny_reg; enz_next = enz_reg;
        cx_next = cx_reg; cy_next = cy_reg; cz_next = cz_reg;
        phase_next = phase_reg; j_next = j_reg; bd_next = bd_reg; bi_next = bi_reg;
        s_next = s_reg; e_next = e_reg; open_next = open_reg; gval_next = gval_reg;
        stamp_next = stamp_reg; found_next = found_reg; bf_next = bf_reg;
        bs_next = bs_reg; cur_next = cur_reg; bg_next = bg_reg; rdp_next = rdp_reg;
        idxd_next = idxd_reg; t_next = t_reg; len_next = len_reg; walk_next = walk_reg;
        stat_next = stat_reg;
        ov_next = ov_reg && !m_tready; olast_next = olast_reg; ost_next = ost_reg;
        oidx_next = oidx_reg; ox_next = ox_reg; oy_next = oy_reg; oz_next = oz_reg;

        cr_we = 1'b0; cr_waddr = count_reg[IDX_W-1:0];
        cr_wdata = {s_tdata[3*COORD_BITS-1:2*COORD_BITS],
                    s_tdata[2*COORD_BITS-1:COORD_BITS], s_tdata[COORD_BITS-1:0]};
        cr_re = 1'b0; cr_raddr = jj;
        sr_we = 1'b0; sr_waddr = jj; sr_wdata = '0;
        sr_re = 1'b0; sr_raddr = jj;
        pr_we = 1'b0; pr_waddr = len_reg[IDX_W-1:0]; pr_wdata = walk_reg;
        pr_re = 1'b0; pr_raddr = jj;
        dreq = '0;

        f_val = {1'b0, sr_rdata.g} + {1'b0, sr_rdata.h};
        t_sum = {1'b0, bg_reg} + (COST_W + 1)'(droot);
        g_n   = gval_reg[jj] ? sr_rdata.g : '1;

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    case (s_tuser)
                        OP_LOAD: begin
                            if (count_reg == CNT_W'(MAX_NODES)) begin
                                stat_next  = ST_FULL;
                                state_next = S_STAT;
                            end else begin
                                cr_we      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_FIND: begin
                            if (count_reg == '0) begin
                                stat_next  = ST_EMPTY;
                                state_next = S_STAT;
                            end else begin
                                qx_next = s_tdata[COORD_BITS-1:0];
                                qy_next = s_tdata[2*COORD_BITS-1:COORD_BITS];
                                qz_next = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
                                gx_next = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
                                gy_next = s_tdata[5*COORD_BITS-1:4*COORD_BITS];
                                gz_next = s_tdata[6*COORD_BITS-1:5*COORD_BITS];
                                phase_next = 1'b0;
                                j_next     = '0;
                                state_next = S_NR_RD;
                            end
                        end
                        OP_CLEAR: count_next = '0;
                        default: ;
                    endcase
                end
            end
            // snap start (phase 0) then goal (phase 1) to the nearest point
            S_NR_RD: begin
                cr_re = 1'b1;
                state_next = S_NR_GO;
            end
            S_NR_GO: begin
                dreq.start = 1'b1;
                state_next = S_NR_WT;
            end
            S_NR_WT: begin
                if (ddone) begin
                    if (j_reg == '0 || dd2 < bd_reg) begin
                        bd_next = dd2;
                        bi_next = jj;
                    end
                    j_next     = j_reg + 1'b1;
                    state_next = S_NR_RD;
                    if (j_reg + 1'b1 == count_reg) begin
                        j_next = '0;
                        if (!phase_reg) begin
                            s_next = (j_reg == '0 || dd2 < bd_reg) ? jj : bi_reg;
                            qx_next = gx_reg; qy_next = gy_reg; qz_next = gz_reg;
                            phase_next = 1'b1;
                        end else begin
                            e_next = (j_reg == '0 || dd2 < bd_reg) ? jj : bi_reg;
                            state_next = S_INIT_E;
                        end
                    end
                end
            end
            S_INIT_E: begin
                cr_re = 1'b1; cr_raddr = e_reg;
                state_next = S_INIT_S;
            end
            S_INIT_S: begin
                enx_next = rx; eny_next = ry; enz_next = rz;
                cr_re = 1'b1; cr_raddr = s_reg;
                state_next = S_INIT_H;
            end
            S_INIT_H: begin
                dreq.start = 1'b1; dreq.root_en = 1'b1;
                state_next = S_INIT_W;
            end
            S_INIT_W: begin
                if (ddone) begin
                    sr_we = 1'b1; sr_waddr = s_reg;
                    sr_wdata.g = '0;
                    sr_wdata.h = COST_W'(droot);
                    sr_wdata.came = s_reg;
                    sr_wdata.stamp = '0;
                    open_next = '0; open_next[s_reg] = 1'b1;
                    gval_next = '0; gval_next[s_reg] = 1'b1;
                    stamp_next = STAMP_W'(1);
                    j_next = '0; found_next = 1'b0; rdp_next = 1'b0;
                    state_next = S_SEL;
                end
            end
            // pick the open node with least f, earliest entry on ties
            S_SEL: begin
                if (rdp_reg && open_reg[idxd_reg]) begin
                    if (!found_reg || f_val < bf_reg ||
                        (f_val == bf_reg && sr_rdata.stamp < bs_reg)) begin
                        found_next = 1'b1;
                        bf_next  = f_val;
                        bs_next  = sr_rdata.stamp;
                        cur_next = idxd_reg;
                        bg_next  = sr_rdata.g;
                    end
                end
                if (j_reg != count_reg) begin
                    sr_re = 1'b1;
                    rdp_next  = 1'b1;
                    idxd_next = jj;
                    j_next    = j_reg + 1'b1;
                end else begin
                    rdp_next = 1'b0;
                    if (!rdp_reg) begin
                        if (!found_reg) begin
                            stat_next  = ST_NOPATH;
                            state_next = S_STAT;
                        end else begin
                            open_next[cur_reg] = 1'b0;
                            if (cur_reg == e_reg) begin
                                len_next   = '0;
                                walk_next  = e_reg;
                                state_next = S_PW;
                            end else begin
                                cr_re = 1'b1; cr_raddr = cur_reg;
                                state_next = S_EX_C;
                            end
                        end
                    end
                end
            end
            S_EX_C: begin
                cx_next = rx; cy_next = ry; cz_next = rz;
                j_next = '0;
                state_next = S_EX_RD;
            end
            // relax every linked neighbor of the current node
            S_EX_RD: begin
                if (j_reg == count_reg) begin
                    j_next = '0; found_next = 1'b0; rdp_next = 1'b0;
                    state_next = S_SEL;
                end else if (jj == cur_reg) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    cr_re = 1'b1;
                    state_next = S_EX_GO;
                end
            end
            S_EX_GO: begin
                dreq.start = 1'b1; dreq.root_en = 1'b1;
                state_next = S_EX_WT;
            end
            S_EX_WT: begin
                if (ddone) begin
                    if (droot > radius_reg) begin
                        j_next = j_reg + 1'b1;
                        state_next = S_EX_RD;
                    end else begin
                        t_next = t_sum[COST_W] ? '1 : t_sum[COST_W-1:0];
                        sr_re = 1'b1;
                        state_next = S_EX_G;
                    end
                end
            end
            S_EX_G: begin
                if (t_reg < g_n) begin
                    dreq.start = 1'b1; dreq.root_en = 1'b1;
                    state_next = S_EX_HW;
                end else begin
                    j_next = j_reg + 1'b1;
                    state_next = S_EX_RD;
                end
            end
            S_EX_HW: begin
                if (ddone) begin
                    sr_we = 1'b1;
                    sr_wdata.g = t_reg;
                    sr_wdata.h = COST_W'(droot);
                    sr_wdata.came = cur_reg;
                    sr_wdata.stamp = open_reg[jj] ? sr_rdata.stamp : stamp_reg;
                    if (!open_reg[jj]) begin
                        open_next[jj] = 1'b1;
                        stamp_next = stamp_reg + 1'b1;
                    end
                    gval_next[jj] = 1'b1;
                    j_next = j_reg + 1'b1;
                    state_next = S_EX_RD;
                end
            end
            // walk back from goal to start, pushing onto the path stack
            S_PW: begin
                if (walk_reg == s_reg) begin
                    pr_we = 1'b1;
                    len_next = len_reg + 1'b1;
                    j_next = len_reg;
                    state_next = S_EM_RD;
                end else if (len_reg >= CNT_W'(MAX_NODES - 1)) begin
                    stat_next  = ST_NOPATH;
                    state_next = S_STAT;
                end else begin
                    pr_we = 1'b1;
                    len_next = len_reg + 1'b1;
                    sr_re = 1'b1; sr_raddr = walk_reg;
                    state_next = S_PW_WT;
                end
            end
            S_PW_WT: begin
                walk_next  = sr_rdata.came;
                state_next = S_PW;
            end
            // pop the stack: start first, goal last
            S_EM_RD: begin
                pr_re = 1'b1;
                state_next = S_EM_P;
            end
            S_EM_P: begin
                cr_re = 1'b1; cr_raddr = pr_rdata;
                idxd_next = pr_rdata;
                state_next = S_EM_O;
            end
            S_EM_O: begin
                if (out_free) begin
                    ov_next = 1'b1; ost_next = ST_PATH; oidx_next = idxd_reg;
                    ox_next = rx; oy_next = ry; oz_next = rz;
                    olast_next = (j_reg == '0);
                    if (j_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        j_next = j_reg - 1'b1;
                        state_next = S_EM_RD;
                    end
                end
            end
            S_STAT: begin
                if (out_free) begin
                    ov_next = 1'b1; ost_next = stat_reg; oidx_next = '0;
                    ox_next = '0; oy_next = '0; oz_next = '0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            radius_reg <= RADIUS_W'(256);
            ov_reg     <= 1'b0;
            rdp_reg    <= 1'b0;
            found_reg  <= 1'b0;
            open_reg   <= '0;
            gval_reg   <= '0;
            stamp_reg  <= '0;
            phase_reg  <= 1'b0;
            j_reg      <= '0;
            len_reg    <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wen) begin
                radius_reg <= cfg_wdata;
            end
            ov_reg    <= ov_next;
            rdp_reg   <= rdp_next;
            found_reg <= found_next;
            open_reg  <= open_next;
            gval_reg  <= gval_next;
            stamp_reg <= stamp_next;
            phase_reg <= phase_next;
            j_reg     <= j_next;
            len_reg   <= len_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        qx_reg <= qx_next; qy_reg <= qy_next; qz_reg <= qz_next;
        gx_reg <= gx_next; gy_reg <= gy_next; gz_reg <= gz_next;
        enx_reg <= enx_next; eny_reg <= eny_next; enz_reg <= enz_next;
        cx_reg <= cx_next; cy_reg <= cy_next; cz_reg <= cz_next;
        bd_reg <= bd_next; bi_reg <= bi_next; s_reg <= s_next; e_reg <= e_next;
        bf_reg <= bf_next; bs_reg <= bs_next; cur_reg <= cur_next; bg_reg <= bg_next;
        idxd_reg <= idxd_next; t_reg <= t_next; walk_reg <= walk_next;
        stat_reg <= stat_next;
        olast_reg <= olast_next; ost_reg <= ost_next; oidx_reg <= oidx_next;
        ox_reg <= ox_next; oy_reg <= oy_next; oz_reg <= oz_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = ost_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = M_DATA_W'({oz_reg, oy_reg, ox_reg, oidx_reg});
endmodule

FILE: sim/tb_astar_radius_graph_path_core.sv
// Self-checking testbench for astar_radius_graph_path_core: directed table, then
// random point sets and path requests checked against an in-bench A* predictor.
// Depends on astarp_pkg and the core RTL.
module tb_astar_radius_graph_path_core;
    timeunit 1ns;
    timeprecision 1ps;
    import astarp_pkg::*;

    localparam int QUIET_LIMIT = 400000;
    localparam int SETTLE      = 200;

    typedef enum {CHK_MODEL, CHK_EMPTY, CHK_NONE} chk_t;

    typedef struct {
        logic [1:0]  st;
        logic [5:0]  idx;
        logic [23:0] x, y, z;
        logic        last;
    } path_res_t;

    typedef struct {
        logic [1:0] op;
        int px, py, pz, ex, ey, ez;
        chk_t chk;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wen = 1'b0;
    logic [RADIUS_W-1:0] cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [1:0]          s_tuser = OP_LOAD;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    // Expected path nodes / status results, oldest first
    path_res_t path_q[$];
    int errors = 0;
    int quiet = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    // Predictor copy of the point table and search state
    logic [RADIUS_W-1:0] radius = 25'd256;
    coord_t pt_x[MAX_NODES], pt_y[MAX_NODES], pt_z[MAX_NODES];
    int pt_cnt = 0;
    logic [31:0] g_c[MAX_NODES], h_c[MAX_NODES];
    int from_n[MAX_NODES], stamp_n[MAX_NODES], stk[MAX_NODES];
    bit open_n[MAX_NODES];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    astar_radius_graph_path_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    function automatic longint unsigned sq_dist(coord_t ax, coord_t ay, coord_t az, int j);
        longint dx, dy, dz;
        dx = longint'(ax) - longint'(pt_x[j]);
        dy = longint'(ay) - longint'(pt_y[j]);
        dz = longint'(az) - longint'(pt_z[j]);
        return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    endfunction

    function automatic logic [31:0] int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] link_len(int a, int b);
        return int_sqrt(sq_dist(pt_x[a], pt_y[a], pt_z[a], b));
    endfunction

    function automatic int snap(coord_t x, coord_t y, coord_t z);
        int best;
        longint unsigned bd, d;
        best = 0;
        bd = sq_dist(x, y, z, 0);
        for (int j = 1; j < pt_cnt; j++) begin
            d = sq_dist(x, y, z, j);
            if (d < bd) begin
                bd = d;
                best = j;
            end
        end
        return best;
    endfunction

    function automatic void push_status(logic [1:0] st);
        path_res_t r;
        r.st = st; r.idx = '0; r.x = '0; r.y = '0; r.z = '0; r.last = 1'b1;
        path_q.insert(path_q.size(), r);
    endfunction

    function automatic void search_path(coord_t sx, coord_t sy, coord_t sz,
                                        coord_t ex, coord_t ey, coord_t ez);
        int s, e, cur, len, n, stamp;
        bit found;
        logic [32:0] f, bf;
        logic [31:0] d, t;
        path_res_t r;
        if (pt_cnt == 0) begin
            push_status(ST_EMPTY);
            return;
        end
        s = snap(sx, sy, sz);
        e = snap(ex, ey, ez);
        stamp = 0;
        for (int i = 0; i < MAX_NODES; i++) begin
            g_c[i] = '1;
            open_n[i] = 1'b0;
        end
        g_c[s] = '0;
        h_c[s] = link_len(s, e);
        open_n[s] = 1'b1;
        stamp_n[s] = stamp++;
        forever begin
            found = 1'b0;
            cur = 0;
            bf = '0;
            for (int i = 0; i < pt_cnt; i++) begin
                if (!open_n[i]) continue;
                f = {1'b0, g_c[i]} + {1'b0, h_c[i]};
                if (!found || f < bf || (f == bf && stamp_n[i] < stamp_n[cur])) begin
                    found = 1'b1;
                    bf = f;
                    cur = i;
                end
            end
            if (!found) break;
            open_n[cur] = 1'b0;
            if (cur == e) begin
                len = 0;
                n = e;
                while (n != s) begin
                    if (len >= MAX_NODES - 1) begin
                        push_status(ST_NOPATH);
                        return;
                    end
                    stk[len++] = n;
                    n = from_n[n];
                end
                stk[len++] = s;
                for (int k = 0; k < len; k++) begin
                    n = stk[len - 1 - k];
                    r.st = ST_PATH; r.idx = n[5:0];
                    r.x = pt_x[n]; r.y = pt_y[n]; r.z = pt_z[n];
                    r.last = (k == len - 1);
                    path_q.insert(path_q.size(), r);
                end
                return;
            end
            for (n = 0; n < pt_cnt; n++) begin
                if (n == cur) continue;
                d = link_len(cur, n);
                if (d > 32'(radius)) continue;
                t = (g_c[cur] > 32'hFFFF_FFFF - d) ? 32'hFFFF_FFFF : g_c[cur] + d;
                if (t < g_c[n]) begin
                    from_n[n] = cur;
                    g_c[n] = t;
                    h_c[n] = link_len(n, e);
                    if (!open_n[n]) begin
                        open_n[n] = 1'b1;
                        stamp_n[n] = stamp++;
                    end
                end
            end
        end
        push_status(ST_NOPATH);
    endfunction

    // Apply one accepted request to the predictor state
    function automatic void predict_request(logic [1:0] op, coord_t c[6]);
        case (op)
            OP_LOAD: begin
                if (pt_cnt >= MAX_NODES) begin
                    push_status(ST_FULL);
                end else begin
                    pt_x[pt_cnt] = c[0]; pt_y[pt_cnt] = c[1]; pt_z[pt_cnt] = c[2];
                    pt_cnt++;
                end
            end
            OP_FIND:  search_path(c[0], c[1], c[2], c[3], c[4], c[5]);
            OP_CLEAR: pt_cnt = 0;
            default: ;
        endcase
    endfunction

    // Drive one request; hold it until accepted, then record what it should produce
    task automatic send_req(logic [1:0] op, int px, int py, int pz, int ex, int ey, int ez,
                            chk_t chk = CHK_MODEL);
        coord_t c[6];
        int n0;
        c[0] = COORD_BITS'(px); c[1] = COORD_BITS'(py); c[2] = COORD_BITS'(pz);
        c[3] = COORD_BITS'(ex); c[4] = COORD_BITS'(ey); c[5] = COORD_BITS'(ez);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {c[5], c[4], c[3], c[2], c[1], c[0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n0 = path_q.size();
        predict_request(op, c);
        if (chk != CHK_MODEL) begin
            while (path_q.size() > n0) void'(path_q.pop_back());
            if (chk == CHK_EMPTY) push_status(ST_EMPTY);
        end
    endtask

    // Drop valid and wait until every result is back and the core has settled
    task automatic drain();
        if (s_tvalid) s_tvalid <= 1'b0;
        @(posedge aclk);
        while (path_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_radius(logic [RADIUS_W-1:0] v);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        radius = v;
    endtask

    function automatic int rnd_coord();
        return int'($urandom_range(24'hFFFFFF)) - 8388608;
    endfunction

    // Receiver: long hold-off when asked, otherwise random stalls
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge aclk) begin
        path_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (path_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d data=%h last=%0d",
                         $time, m_tuser, m_tdata, m_tlast);
                errors++;
            end else begin
                e = path_q.pop_front();
                if (m_tuser !== e.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, m_tuser);
                    errors++;
                end
                if (m_tdata[5:0] !== e.idx) begin
                    $display("%0t: node_index expected %0d actual %0d", $time, e.idx,
                             m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[29:6] !== e.x) begin
                    $display("%0t: out_x expected %h actual %h", $time, e.x, m_tdata[29:6]);
                    errors++;
                end
                if (m_tdata[53:30] !== e.y) begin
                    $display("%0t: out_y expected %h actual %h", $time, e.y, m_tdata[53:30]);
                    errors++;
                end
                if (m_tdata[77:54] !== e.z) begin
                    $display("%0t: out_z expected %h actual %h", $time, e.z, m_tdata[77:54]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no request or result moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Directed rows: empty table, unknown op, coordinate extremes, bit patterns,
    // duplicate points for nearest ties, a short chain, clear
    dir_row_t dir_tab[20] = '{
        '{OP_FIND,  0, 0, 0, 0, 0, 0, CHK_EMPTY},
        '{2'd3,     5, 5, 5, 5, 5, 5, CHK_NONE},
        '{OP_LOAD,  8388607, 8388607, 8388607, 8388607, 8388607, 8388607, CHK_NONE},
        '{OP_LOAD,  -8388608, -8388608, -8388608, -8388608, -8388608, -8388608, CHK_NONE},
        '{OP_FIND,  8388607, 8388607, 8388607, -8388608, -8388608, -8388608, CHK_MODEL},
        '{OP_FIND,  8388607, 8388607, 8388607, 8388607, 8388607, 8388600, CHK_MODEL},
        '{OP_CLEAR, 0, 0, 0, 0, 0, 0, CHK_NONE},
        '{OP_FIND,  1, 2, 3, 4, 5, 6, CHK_EMPTY},
        '{OP_LOAD,  0, 0, 0, 'hAAAAAA, 'h555555, 'hAAAAAA, CHK_NONE},
        '{OP_LOAD,  256, 0, 0, 'h555555, 'hAAAAAA, 'h555555, CHK_NONE},
        '{OP_LOAD,  512, 0, 0, 0, 0, 0, CHK_NONE},
        '{OP_LOAD,  256, 200, 0, 0, 0, 0, CHK_NONE},
        '{OP_LOAD,  512, 0, 0, 0, 0, 0, CHK_NONE},
        '{OP_FIND,  -10, 3, 0, 600, 0, 0, CHK_MODEL},
        '{OP_FIND,  512, 0, 0, 0, 0, 0, CHK_MODEL},
        '{OP_FIND,  300, 300, 0, 300, 300, 0, CHK_MODEL},
        '{OP_LOAD,  'hAAAAAA, 'h555555, 'hAAAAAA, 0, 0, 0, CHK_NONE},
        '{OP_LOAD,  'h555555, 'hAAAAAA, 'h555555, 0, 0, 0, CHK_NONE},
        '{OP_FIND,  'hAAAAAA, 0, 0, 'h555555, 0, 0, CHK_MODEL},
        '{OP_CLEAR, 0, 0, 0, 0, 0, 0, CHK_NONE}
    };

    initial begin
        int rad_tab[6];
        int k, spread, bx, by, bz, a, b, j;
        int cx[MAX_NODES], cy[MAX_NODES], cz[MAX_NODES];

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset radius of 256
        foreach (dir_tab[i])
            send_req(dir_tab[i].op, dir_tab[i].px, dir_tab[i].py, dir_tab[i].pz,
                     dir_tab[i].ex, dir_tab[i].ey, dir_tab[i].ez, dir_tab[i].chk);

        // Random part: one point cluster per phase, radius and idling vary
        rad_tab = '{256, 0, 33554431, int'($urandom_range(1, 2000)), 1000,
                    int'($urandom_range(33554431))};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) write_radius(RADIUS_W'(rad_tab[ph]));
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            spread = (rad_tab[ph] > 700000) ? 1048576 : rad_tab[ph] * 3 / 2 + 4;
            bx = int'($urandom_range(8388607)) - 4194304;
            by = int'($urandom_range(8388607)) - 4194304;
            bz = int'($urandom_range(8388607)) - 4194304;
            send_req(OP_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), 0, 0, 0);
            k = $urandom_range(2, 10);
            for (int i = 0; i < k; i++) begin
                cx[i] = bx + int'($urandom_range(spread)) - spread / 2;
                cy[i] = by + int'($urandom_range(spread)) - spread / 2;
                cz[i] = bz + int'($urandom_range(spread / 4 + 1));
                send_req(OP_LOAD, cx[i], cy[i], cz[i], rnd_coord(), rnd_coord(), rnd_coord());
            end
            for (int q = 0; q < 4; q++) begin
                a = $urandom_range(k - 1);
                b = $urandom_range(k - 1);
                if (q == 3) begin
                    // noise: unknown op or a query from anywhere
                    send_req($urandom_range(1) ? 2'd3 : OP_FIND, rnd_coord(), rnd_coord(),
                             rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
                end else begin
                    send_req(OP_FIND, cx[a] + int'($urandom_range(6)) - 3, cy[a], cz[a],
                             cx[b], cy[b] + int'($urandom_range(6)) - 3, cz[b]);
                end
            end
        end

        // Fill the table, then keep offering loads while the receiver holds off
        write_radius(25'd0);
        idle_pct = 0;
        stall_pct = 0;
        send_req(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < MAX_NODES; i++)
            send_req(OP_LOAD, rnd_coord(), rnd_coord(), rnd_coord(), 0, 0, 0);
        hold_left = 3000;
        for (int i = 0; i < 5; i++)
            send_req(OP_LOAD, rnd_coord(), rnd_coord(), rnd_coord(), 0, 0, 0);
        drain();
        // Radius zero on a full table: only the start expands
        j = $urandom_range(MAX_NODES - 1);
        send_req(OP_FIND, pt_x[j], pt_y[j], pt_z[j], rnd_coord(), rnd_coord(), rnd_coord());
        send_req(OP_FIND, pt_x[j], pt_y[j], pt_z[j], pt_x[j], pt_y[j], pt_z[j]);
        send_req(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        send_req(OP_FIND, 0, 0, 0, 0, 0, 0, CHK_EMPTY);

        drain();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
